>>> rtl/value_noise_3d_assert.svh
// Assertion macros for the value noise RTL.
`ifndef VALUE_NOISE_3D_ASSERT_SVH
`define VALUE_NOISE_3D_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define VN3_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("value_noise_3d: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define VN3_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("value_noise_3d: next-cycle check failed");

`endif

>>> rtl/vn3_pkg.sv
// Shared constants, tables and types for the 3D value noise pipeline.
`default_nettype none

package vn3_pkg;

    localparam int COORD_W       = 32;
    localparam int CORNER_W      = 16;
    localparam int CELL_W        = 9;
    localparam int DEF_FRAC_BITS = 16;

    localparam int HASH_MOD = 289;
    localparam int VAL_MOD  = 41;

    // floor(2^32 / 289): reciprocal for reducing values below 2^24 mod 289.
    localparam logic [23:0] RECIP289 = 24'd14861478;
    // ceil(2^16 / 41): exact floor(h / 41) for every hash value below 289.
    localparam logic [10:0] RECIP41 = 11'd1599;

    // Largest corner value, floor(40 * 65536 / 41).
    localparam logic [CORNER_W-1:0] CORNER_MAX = 16'd63937;

    typedef logic [CORNER_W-1:0] corner_lut_t [VAL_MOD];

    function automatic corner_lut_t build_corner_lut();
        corner_lut_t lut;
        for (int m = 0; m < VAL_MOD; m++)
        begin
            lut[m] = CORNER_W'((m * 65536) / VAL_MOD);
        end
        return lut;
    endfunction

    // Corner value for each residue of the hash mod 41.
    localparam corner_lut_t CORNER_LUT = build_corner_lut();

endpackage

`default_nettype wire

>>> rtl/vn3_perm.sv
// Three-stage pipelined permutation polynomial ((34v + 1) v) mod 289.
`default_nettype none

module vn3_perm (
    input  wire logic                      clk,
    input  wire logic                      en,
    input  wire logic [9:0]                v,
    output logic      [vn3_pkg::CELL_W-1:0] h
);

    logic [8:0]  r;
    logic [13:0] lin;
    logic [21:0] t_next;
    logic [21:0] t_reg;
    logic [45:0] qp_next;
    logic [45:0] qp_reg;
    logic [21:0] t_b_reg;
    logic [13:0] q;
    logic [21:0] rem;
    logic [9:0]  rem_lo;
    logic [8:0]  h_next;
    logic [8:0]  h_reg;

    // The argument is below twice the modulus, so one subtraction reduces it.
    always_comb
    begin
        r = (v >= 10'(vn3_pkg::HASH_MOD)) ? 9'(v - 10'(vn3_pkg::HASH_MOD)) : v[8:0];
        lin = 14'(r) * 14'd34 + 14'd1;
        t_next = 22'(lin) * 22'(r);
    end

    assign qp_next = 46'(t_reg) * 46'(vn3_pkg::RECIP289);

    // The estimated quotient is at most one low, so one correction remains.
    always_comb
    begin
        q = qp_reg[45:32];
        rem = t_b_reg - 22'(q) * 22'(vn3_pkg::HASH_MOD);
        rem_lo = rem[9:0];
        h_next = (rem_lo >= 10'(vn3_pkg::HASH_MOD)) ?
                 9'(rem_lo - 10'(vn3_pkg::HASH_MOD)) : rem_lo[8:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg   <= t_next;
            qp_reg  <= qp_next;
            t_b_reg <= t_reg;
            h_reg   <= h_next;
        end
    end

    assign h = h_reg;

endmodule

`default_nettype wire

>>> rtl/value_noise_3d.sv
// Top level of the pipelined 3D value noise generator.
//
// Usage: a request on the input channel (in_valid/in_ready) carries one point
// px, py, pz in signed fixed point with FRAC_BITS fraction bits. Each request
// yields exactly one result on the output channel (out_valid/out_ready):
// noise_value, an unsigned 0.16 fraction in [0, 1).
// Throughput is one request per cycle while in_ready is high. The datapath has
// 18 register stages and a two-entry output buffer. Three stages split the
// coordinates, nine run the three chained hash permutations, one looks up the
// corner values, and the three blend passes take two each, the last one ending
// in the output register.
// When the receiver stalls, the finished result waits in the output register
// and one more result may land in the skid register behind it; once that
// register is occupied, in_ready drops and the whole pipeline holds in place.
// Every 32-bit pattern is a legal coordinate; nothing saturates.
// Reset (rst_n, asynchronous, active low) empties the pipeline and the output
// buffer; no request is lost or repeated across a stall.
`default_nettype none
`include "value_noise_3d_assert.svh"

module value_noise_3d #(
    parameter int FRAC_BITS = vn3_pkg::DEF_FRAC_BITS
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic signed [vn3_pkg::COORD_W-1:0]   px,
    input  wire logic signed [vn3_pkg::COORD_W-1:0]   py,
    input  wire logic signed [vn3_pkg::COORD_W-1:0]   pz,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic             [vn3_pkg::CORNER_W-1:0]  noise_value
);

    localparam int INT_W = vn3_pkg::COORD_W - FRAC_BITS;
    localparam int SQ_W  = 2 * FRAC_BITS;
    localparam int K_W   = FRAC_BITS + 2;
    localparam int SM_W  = 2 * FRAC_BITS + 2;
    localparam int BL_W  = vn3_pkg::CORNER_W + FRAC_BITS + 2;
    localparam int CW    = vn3_pkg::CELL_W;
    localparam int VW    = vn3_pkg::CORNER_W;

    // 2^INT_W mod 289: moves a two's complement cell index to its true residue.
    localparam logic [CW-1:0] NEG_ADJ = CW'((64'd1 << INT_W) % vn3_pkg::HASH_MOD);

    localparam int PIPE_DEPTH = 18;
    localparam int DLY_CY = 3;
    localparam int DLY_CZ = 6;
    localparam int DLY_WZ = 10;
    localparam int DLY_WX = 12;
    localparam int DLY_WY = 14;

    // Blend step, first half: (b - a) * w as an exact signed product.
    function automatic logic signed [BL_W-1:0] blend_mul(
        input logic [VW-1:0]        a,
        input logic [VW-1:0]        b,
        input logic [FRAC_BITS-1:0] w
    );
        logic signed [VW:0]        diff;
        logic signed [BL_W-1:0]    diff_x;
        logic signed [BL_W-1:0]    w_x;
        diff   = $signed({1'b0, b}) - $signed({1'b0, a});
        diff_x = BL_W'(diff);
        w_x    = $signed(BL_W'(w));
        return diff_x * w_x;
    endfunction

    // Blend step, second half: the arithmetic shift floors toward minus infinity.
    function automatic logic [VW-1:0] blend_fin(
        input logic [VW-1:0]        a,
        input logic signed [BL_W-1:0] t
    );
        logic signed [BL_W-1:0] sum;
        sum = $signed(BL_W'(a)) + (t >>> FRAC_BITS);
        return sum[VW-1:0];
    endfunction

    // Corner value: hash mod 41 by reciprocal, then the constant table.
    function automatic logic [VW-1:0] corner_of(input logic [CW-1:0] hv);
        logic [18:0]   p;
        logic [2:0]    q;
        logic [CW-1:0] m;
        p = 19'(hv) * 19'(vn3_pkg::RECIP41);
        q = p[18:16];
        m = hv - CW'(q) * CW'(vn3_pkg::VAL_MOD);
        return vn3_pkg::CORNER_LUT[m[5:0]];
    endfunction

    // Pipeline control: the whole pipeline advances unless the skid register
    // is occupied; valid bits shift along with the data.
    logic                  en;
    logic                  push;
    logic                  pop;
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic                  head_vld_reg;
    logic                  skid_vld_reg;
    logic [VW-1:0]         head_data_reg;
    logic [VW-1:0]         skid_data_reg;
    logic [VW-1:0]         res_next;

    assign en       = !skid_vld_reg;
    assign in_ready = en;
    assign push     = en && vld_reg[PIPE_DEPTH-1];
    assign pop      = head_vld_reg && out_ready;

    // Stages 1 to 3: split each coordinate into cell index mod 289 and the
    // smoothstep weight of its fraction.
    logic [vn3_pkg::COORD_W-1:0] coord [3];
    logic [23:0]          u_s1_reg   [3];
    logic                 neg_s1_reg [3];
    logic [47:0]          cm_s1_reg  [3];
    logic [FRAC_BITS-1:0] d_s1_reg   [3];
    logic [SQ_W-1:0]      dd_s1_reg  [3];
    logic [9:0]           r_s2_reg   [3];
    logic                 neg_s2_reg [3];
    logic [SM_W-1:0]      sm_s2_reg  [3];
    logic [CW-1:0]        cell_s3_reg [3];
    logic [FRAC_BITS-1:0] w_s3_reg   [3];

    assign coord[0] = px;
    assign coord[1] = py;
    assign coord[2] = pz;

    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        logic [23:0]          u_next;
        logic [FRAC_BITS-1:0] d_next;
        logic [15:0]          q;
        logic [24:0]          r_full;
        logic [FRAC_BITS-1:0] dd_hi;
        logic [K_W-1:0]       k;
        logic [CW-1:0]        r1;
        logic [CW-1:0]        cell_next;

        always_comb
        begin
            u_next = 24'(coord[a][vn3_pkg::COORD_W-1:FRAC_BITS]);
            d_next = coord[a][FRAC_BITS-1:0];
            q      = cm_s1_reg[a][47:32];
            r_full = {1'b0, u_s1_reg[a]} - 25'(q) * 25'(vn3_pkg::HASH_MOD);
            dd_hi  = dd_s1_reg[a][SQ_W-1:FRAC_BITS];
            k      = (K_W'(3) << FRAC_BITS) - K_W'({d_s1_reg[a], 1'b0});
            r1     = (r_s2_reg[a] >= 10'(vn3_pkg::HASH_MOD)) ?
                     CW'(r_s2_reg[a] - 10'(vn3_pkg::HASH_MOD)) : r_s2_reg[a][CW-1:0];
            // A negative coordinate's index was taken as unsigned, which is
            // 2^INT_W too large; subtract that residue modulo 289.
            if (!neg_s2_reg[a])
                cell_next = r1;
            else if (r1 >= NEG_ADJ)
                cell_next = r1 - NEG_ADJ;
            else
                cell_next = CW'(10'(r1) + 10'(vn3_pkg::HASH_MOD) - 10'(NEG_ADJ));
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                u_s1_reg[a]    <= u_next;
                neg_s1_reg[a]  <= coord[a][vn3_pkg::COORD_W-1];
                cm_s1_reg[a]   <= 48'(u_next) * 48'(vn3_pkg::RECIP289);
                d_s1_reg[a]    <= d_next;
                dd_s1_reg[a]   <= SQ_W'(d_next) * SQ_W'(d_next);
                r_s2_reg[a]    <= r_full[9:0];
                neg_s2_reg[a]  <= neg_s1_reg[a];
                sm_s2_reg[a]   <= SM_W'(dd_hi) * SM_W'(k);
                cell_s3_reg[a] <= cell_next;
                w_s3_reg[a]    <= sm_s2_reg[a][SQ_W-1:FRAC_BITS];
            end
        end
    end

    // Delay lines that line up the y and z cells and the weights with the hash
    // and blend stages that use them.
    logic [CW-1:0]        cy_dly_reg [DLY_CY];
    logic [CW-1:0]        cz_dly_reg [DLY_CZ];
    logic [FRAC_BITS-1:0] wz_dly_reg [DLY_WZ];
    logic [FRAC_BITS-1:0] wx_dly_reg [DLY_WX];
    logic [FRAC_BITS-1:0] wy_dly_reg [DLY_WY];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cy_dly_reg[0] <= cell_s3_reg[1];
            cz_dly_reg[0] <= cell_s3_reg[2];
            wx_dly_reg[0] <= w_s3_reg[0];
            wy_dly_reg[0] <= w_s3_reg[1];
            wz_dly_reg[0] <= w_s3_reg[2];
            for (int k = 1; k < DLY_CY; k++)
                cy_dly_reg[k] <= cy_dly_reg[k-1];
            for (int k = 1; k < DLY_CZ; k++)
                cz_dly_reg[k] <= cz_dly_reg[k-1];
            for (int k = 1; k < DLY_WZ; k++)
                wz_dly_reg[k] <= wz_dly_reg[k-1];
            for (int k = 1; k < DLY_WX; k++)
                wx_dly_reg[k] <= wx_dly_reg[k-1];
            for (int k = 1; k < DLY_WY; k++)
                wy_dly_reg[k] <= wy_dly_reg[k-1];
        end
    end

    // Stages 4 to 12: three chained permutation levels, one per axis.
    logic [CW-1:0] hx  [2];
    logic [CW-1:0] hxy [2][2];
    logic [CW-1:0] hc  [2][2][2];

    for (genvar i = 0; i < 2; i++)
    begin : g_hx
        vn3_perm u_perm_x (
            .clk (clk),
            .en  (en),
            .v   (10'(cell_s3_reg[0]) + 10'(i)),
            .h   (hx[i])
        );
    end

    for (genvar j = 0; j < 2; j++)
    begin : g_hy
        for (genvar i = 0; i < 2; i++)
        begin : g_hyi
            vn3_perm u_perm_y (
                .clk (clk),
                .en  (en),
                .v   (10'(hx[i]) + 10'(cy_dly_reg[DLY_CY-1]) + 10'(j)),
                .h   (hxy[j][i])
            );
            for (genvar k = 0; k < 2; k++)
            begin : g_hz
                vn3_perm u_perm_z (
                    .clk (clk),
                    .en  (en),
                    .v   (10'(hxy[j][i]) + 10'(cz_dly_reg[DLY_CZ-1]) + 10'(k)),
                    .h   (hc[j][i][k])
                );
            end
        end
    end

    // Stages 13 to 18: corner values, then blends along z, x and y.
    logic [VW-1:0]          cv_reg [2][2][2];
    logic signed [BL_W-1:0] zt_reg [2][2];
    logic [VW-1:0]          za_reg [2][2];
    logic [VW-1:0]          zl_reg [2][2];
    logic signed [BL_W-1:0] xt_reg [2];
    logic [VW-1:0]          xa_reg [2];
    logic [VW-1:0]          xl_reg [2];
    logic signed [BL_W-1:0] yt_reg;
    logic [VW-1:0]          ya_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 2; j++)
            begin
                for (int i = 0; i < 2; i++)
                begin
                    for (int k = 0; k < 2; k++)
                        cv_reg[j][i][k] <= corner_of(hc[j][i][k]);
                    zt_reg[j][i] <= blend_mul(cv_reg[j][i][0], cv_reg[j][i][1],
                                              wz_dly_reg[DLY_WZ-1]);
                    za_reg[j][i] <= cv_reg[j][i][0];
                    zl_reg[j][i] <= blend_fin(za_reg[j][i], zt_reg[j][i]);
                end
                xt_reg[j] <= blend_mul(zl_reg[j][0], zl_reg[j][1], wx_dly_reg[DLY_WX-1]);
                xa_reg[j] <= zl_reg[j][0];
                xl_reg[j] <= blend_fin(xa_reg[j], xt_reg[j]);
            end
            yt_reg <= blend_mul(xl_reg[0], xl_reg[1], wy_dly_reg[DLY_WY-1]);
            ya_reg <= xl_reg[0];
        end
    end

    // The last blend finishes on the way into the output buffer.
    assign res_next = blend_fin(ya_reg, yt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            head_vld_reg <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            if (en)
                vld_reg <= {vld_reg[PIPE_DEPTH-2:0], in_valid};
            if (skid_vld_reg)
            begin
                if (pop)
                    skid_vld_reg <= 1'b0;
            end
            else if (push)
            begin
                if (head_vld_reg && !out_ready)
                    skid_vld_reg <= 1'b1;
                else
                    head_vld_reg <= 1'b1;
            end
            else if (pop)
            begin
                head_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_vld_reg)
        begin
            if (pop)
                head_data_reg <= skid_data_reg;
        end
        else if (push)
        begin
            if (head_vld_reg && !out_ready)
                skid_data_reg <= res_next;
            else
                head_data_reg <= res_next;
        end
    end

    assign out_valid   = head_vld_reg;
    assign noise_value = head_data_reg;

    // The skid register only fills behind a waiting result.
    `VN3_ASSERT_IMPLIES(a_skid_behind_head, clk, rst_n, skid_vld_reg, head_vld_reg)
    // A stalled pipeline keeps its valid bits.
    `VN3_ASSERT_NEXT(a_stall_holds_valids, clk, rst_n, !en, $stable(vld_reg))
    // A result arriving behind a stalled one goes to the skid register.
    `VN3_ASSERT_NEXT(a_push_to_skid, clk, rst_n, push && head_vld_reg && !out_ready,
        skid_vld_reg)
    // Blends stay between corner values, so no result exceeds the largest one.
    `VN3_ASSERT_IMPLIES(a_result_bound, clk, rst_n, head_vld_reg,
        head_data_reg <= vn3_pkg::CORNER_MAX)

endmodule

`default_nettype wire
